>>> hw/rtl/qsbs_pkg.sv
// Shared types and constants for the quicksort buffer sorter.
`default_nettype none
package qsbs_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int STACK_AW    = 6;
  localparam int SP_W        = 7;
  localparam int IN_W        = 32;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_POP, S_RANGE, S_PIV, S_SCANI, S_SCANJ, S_SW1, S_SW2,
    S_FIN1, S_FIN2, S_PUSHA, S_PUSHB, S_ORD, S_OLD, S_OWAIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_STORE, OP_PUSH0, OP_POP, OP_RANGE, OP_PIV, OP_IINC, OP_IEND,
    OP_JDEC, OP_SW1, OP_SW2, OP_FIN1, OP_FIN2, OP_PUSHA, OP_PUSHB, OP_ORD,
    OP_OLD, OP_OACK
  } op_t;

  typedef struct packed {
    logic cnt_ge2;
    logic sp_zero;
    logic range_ok;
    logic i_cont;
    logic j_cont;
    logic i_lt_j;
    logic k_last;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/quicksort_buffer_sorter.sv
// Top level of the quicksort buffer sorter.
//  channel | dir | ports                          | content
//  in_     | in  | tvalid tready tdata[31:0] tlast| value, last_item
//  out_    | out | tvalid tready tdata[31:0] tlast tuser | sorted_value, last_out, overflow
// Loading takes one cycle per item; the item marked last starts the sort.
// Each partition scan step reads one buffer entry per cycle (single read port);
// each subrange is popped, its pivot read, scanned from both ends with swaps, then
// the pivot is placed and parts of two or more items are pushed. Each result is read,
// registered and held until taken; no item is accepted from sort start until the
// final result transfers. Reset (rst_n low, synchronous) empties the buffer.
`default_nettype none
module quicksort_buffer_sorter #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,   // last_item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] sorted_value
  output logic             out_tlast,  // last_out
  output logic             out_tuser   // [0] overflow
);

  qsbs_pkg::op_t     op;
  qsbs_pkg::status_t st;

  qsbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .st         (st),
    .op         (op),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  qsbs_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_value  (in_tdata),
    .st        (st),
    .out_value (out_tdata),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

endmodule
`default_nettype wire

>>> hw/rtl/qsbs_ctrl.sv
// Sequencer for loading, partitioning and emitting the buffer.
`default_nettype none
module qsbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_last,
  input  wire logic              out_tready,
  input  wire qsbs_pkg::status_t st,
  output qsbs_pkg::op_t          op,
  output logic                   in_tready,
  output logic                   out_tvalid
);

  qsbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qsbs_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op         = qsbs_pkg::OP_NONE;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      qsbs_pkg::S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op = qsbs_pkg::OP_STORE;
          if (in_last) state_nxt = qsbs_pkg::S_START;
        end
      end
      qsbs_pkg::S_START: begin
        if (st.cnt_ge2) begin
          op        = qsbs_pkg::OP_PUSH0;
          state_nxt = qsbs_pkg::S_POP;
        end else begin
          state_nxt = qsbs_pkg::S_ORD;
        end
      end
      qsbs_pkg::S_POP: begin
        if (st.sp_zero) begin
          state_nxt = qsbs_pkg::S_ORD;
        end else begin
          op        = qsbs_pkg::OP_POP;
          state_nxt = qsbs_pkg::S_RANGE;
        end
      end
      qsbs_pkg::S_RANGE: begin
        if (st.range_ok) begin
          op        = qsbs_pkg::OP_RANGE;
          state_nxt = qsbs_pkg::S_PIV;
        end else begin
          state_nxt = qsbs_pkg::S_POP;
        end
      end
      qsbs_pkg::S_PIV: begin
        op        = qsbs_pkg::OP_PIV;
        state_nxt = qsbs_pkg::S_SCANI;
      end
      qsbs_pkg::S_SCANI: begin
        if (st.i_cont) begin
          op = qsbs_pkg::OP_IINC;
        end else begin
          op        = qsbs_pkg::OP_IEND;
          state_nxt = qsbs_pkg::S_SCANJ;
        end
      end
      qsbs_pkg::S_SCANJ: begin
        if (st.j_cont) begin
          op = qsbs_pkg::OP_JDEC;
        end else if (st.i_lt_j) begin
          op        = qsbs_pkg::OP_SW1;
          state_nxt = qsbs_pkg::S_SW2;
        end else begin
          op        = qsbs_pkg::OP_FIN1;
          state_nxt = qsbs_pkg::S_FIN2;
        end
      end
      qsbs_pkg::S_SW2: begin
        op        = qsbs_pkg::OP_SW2;
        state_nxt = qsbs_pkg::S_SCANI;
      end
      qsbs_pkg::S_SW1: begin
        state_nxt = qsbs_pkg::S_SW2;
      end
      qsbs_pkg::S_FIN1: begin
        state_nxt = qsbs_pkg::S_FIN2;
      end
      qsbs_pkg::S_FIN2: begin
        op        = qsbs_pkg::OP_FIN2;
        state_nxt = qsbs_pkg::S_PUSHA;
      end
      qsbs_pkg::S_PUSHA: begin
        op        = qsbs_pkg::OP_PUSHA;
        state_nxt = qsbs_pkg::S_PUSHB;
      end
      qsbs_pkg::S_PUSHB: begin
        op        = qsbs_pkg::OP_PUSHB;
        state_nxt = qsbs_pkg::S_POP;
      end
      qsbs_pkg::S_ORD: begin
        op        = qsbs_pkg::OP_ORD;
        state_nxt = qsbs_pkg::S_OLD;
      end
      qsbs_pkg::S_OLD: begin
        op        = qsbs_pkg::OP_OLD;
        state_nxt = qsbs_pkg::S_OWAIT;
      end
      qsbs_pkg::S_OWAIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          op        = qsbs_pkg::OP_OACK;
          state_nxt = st.k_last ? qsbs_pkg::S_LOAD : qsbs_pkg::S_ORD;
        end
      end
      default: state_nxt = qsbs_pkg::S_LOAD;
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output open together");
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_last) |=> (state_r == qsbs_pkg::S_START))
    else $error("last item did not start the sort");
  a_ret_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && st.k_last) |=> in_tready)
    else $error("no return to loading after final result");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/qsbs_dp.sv
// Element buffer, range stack, partition registers and output register.
`default_nettype none
module qsbs_dp #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire qsbs_pkg::op_t         op,
  input  wire logic [qsbs_pkg::IN_W-1:0] in_value,
  output qsbs_pkg::status_t          st,
  output logic [qsbs_pkg::IN_W-1:0]  out_value,
  output logic                       out_last,
  output logic                       out_ovf
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = 2 * AW;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

  logic signed [DATA_WIDTH-1:0] mem [MAX_ITEMS];
  logic [SW-1:0]                stk [qsbs_pkg::STACK_DEPTH];

  logic signed [DATA_WIDTH-1:0] rdata_r, pivot_r, vi_r;
  logic [SW-1:0]                srd_r;
  logic [CW-1:0]                cnt_r, i_r, k_r;
  logic [AW-1:0]                lo_r, hi_r, j_r;
  logic [qsbs_pkg::SP_W-1:0]    sp_r;
  logic                         drop_r;
  logic [qsbs_pkg::IN_W-1:0]    out_value_r;
  logic                         out_last_r, out_ovf_r;

  logic signed [DATA_WIDTH-1:0] in_ext, wdata;
  logic                         we, re, swe;
  logic [AW-1:0]                waddr, raddr;
  logic [SW-1:0]                swdata;
  logic [qsbs_pkg::STACK_AW-1:0] saddr;
  logic [AW-1:0]                srd_lo, srd_hi;
  logic                         left_ok, right_ok, left_big, push_left, full;
  logic [SW-1:0]                left_e, right_e;

  assign srd_lo = srd_r[SW-1:AW];
  assign srd_hi = srd_r[AW-1:0];
  assign full   = (cnt_r == MAXC);

  // Truncate or sign-extend the 32-bit value to the element width.
  assign in_ext = DATA_WIDTH'($signed(in_value));

  // Subranges left of and right of the pivot slot.
  assign left_ok  = (j_r > lo_r) && ((j_r - lo_r) > AW'(1));
  assign right_ok = (hi_r > j_r) && ((hi_r - j_r) > AW'(1));
  assign left_big = (j_r - lo_r) > (hi_r - j_r);
  assign left_e   = {lo_r, AW'(j_r - AW'(1))};
  assign right_e  = {AW'(j_r + AW'(1)), hi_r};
  // Larger part goes on first so the smaller part is popped next.
  assign push_left = (op == qsbs_pkg::OP_PUSHA) ? left_big : !left_big;

  assign st.cnt_ge2  = (cnt_r >= CW'(2));
  assign st.sp_zero  = (sp_r == '0);
  assign st.range_ok = (srd_lo < srd_hi);
  assign st.i_cont   = (i_r <= CW'(hi_r)) && (rdata_r <= pivot_r);
  assign st.j_cont   = (j_r > lo_r) && (rdata_r > pivot_r);
  assign st.i_lt_j   = (i_r < CW'(j_r));
  assign st.k_last   = (k_r == cnt_r - CW'(1));

  always_comb begin
    we     = 1'b0;
    waddr  = '0;
    wdata  = rdata_r;
    re     = 1'b0;
    raddr  = '0;
    swe    = 1'b0;
    saddr  = '0;
    swdata = '0;
    case (op)
      qsbs_pkg::OP_STORE: begin
        we    = !full;
        waddr = cnt_r[AW-1:0];
        wdata = in_ext;
      end
      qsbs_pkg::OP_PUSH0: begin
        swe    = 1'b1;
        swdata = {AW'(0), AW'(cnt_r - CW'(1))};
      end
      qsbs_pkg::OP_RANGE: begin
        re    = 1'b1;
        raddr = srd_lo;
      end
      qsbs_pkg::OP_PIV: begin
        re    = 1'b1;
        raddr = AW'(lo_r + AW'(1));
      end
      qsbs_pkg::OP_IINC: begin
        re    = 1'b1;
        raddr = AW'(i_r + CW'(1));
      end
      qsbs_pkg::OP_IEND: begin
        re    = 1'b1;
        raddr = j_r;
      end
      qsbs_pkg::OP_JDEC: begin
        re    = 1'b1;
        raddr = AW'(j_r - AW'(1));
      end
      qsbs_pkg::OP_SW1: begin
        we    = 1'b1;
        waddr = i_r[AW-1:0];
      end
      qsbs_pkg::OP_SW2: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = vi_r;
        re    = 1'b1;
        raddr = i_r[AW-1:0];
      end
      qsbs_pkg::OP_FIN1: begin
        we    = 1'b1;
        waddr = lo_r;
      end
      qsbs_pkg::OP_FIN2: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = pivot_r;
      end
      qsbs_pkg::OP_PUSHA, qsbs_pkg::OP_PUSHB: begin
        swe    = (push_left ? left_ok : right_ok) &&
                 (sp_r < qsbs_pkg::SP_W'(qsbs_pkg::STACK_DEPTH));
        saddr  = sp_r[qsbs_pkg::STACK_AW-1:0];
        swdata = push_left ? left_e : right_e;
      end
      qsbs_pkg::OP_ORD: begin
        re    = 1'b1;
        raddr = k_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
    if (swe) stk[saddr] <= swdata;
    if (op == qsbs_pkg::OP_POP) srd_r <= stk[qsbs_pkg::STACK_AW'(sp_r - qsbs_pkg::SP_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      sp_r   <= '0;
      k_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      lo_r   <= '0;
      hi_r   <= '0;
    end else begin
      case (op)
        qsbs_pkg::OP_STORE: begin
          if (full) drop_r <= 1'b1;
          else cnt_r <= cnt_r + CW'(1);
          k_r <= '0;
        end
        qsbs_pkg::OP_PUSH0: sp_r <= qsbs_pkg::SP_W'(1);
        qsbs_pkg::OP_POP:   sp_r <= sp_r - qsbs_pkg::SP_W'(1);
        qsbs_pkg::OP_RANGE: begin
          lo_r <= srd_lo;
          hi_r <= srd_hi;
        end
        qsbs_pkg::OP_PIV: begin
          i_r <= CW'(lo_r) + CW'(1);
          j_r <= hi_r;
        end
        qsbs_pkg::OP_IINC: i_r <= i_r + CW'(1);
        qsbs_pkg::OP_JDEC: j_r <= j_r - AW'(1);
        qsbs_pkg::OP_PUSHA, qsbs_pkg::OP_PUSHB: begin
          if (swe) sp_r <= sp_r + qsbs_pkg::SP_W'(1);
        end
        qsbs_pkg::OP_OACK: begin
          if (st.k_last) begin
            cnt_r  <= '0;
            drop_r <= 1'b0;
            k_r    <= '0;
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == qsbs_pkg::OP_PIV) pivot_r <= rdata_r;
    if (op == qsbs_pkg::OP_IEND) vi_r <= rdata_r;
    if (op == qsbs_pkg::OP_OLD) begin
      out_value_r <= qsbs_pkg::IN_W'(rdata_r);
      out_last_r  <= st.k_last;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXC) else $error("item count beyond capacity");
  a_sp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= qsbs_pkg::SP_W'(qsbs_pkg::STACK_DEPTH)) else $error("range stack overrun");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (op == qsbs_pkg::OP_IINC) |-> (i_r <= CW'(hi_r))) else $error("scan past range bound");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (op == qsbs_pkg::OP_STORE && !full) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("store did not advance count");
`endif

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the quicksort buffer sorter.
`timescale 1ns / 100ps
module tb_top;

  localparam int CAPACITY   = 64;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] value;
    logic        last_item;
  } load_item_t;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflow;
  } sorted_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  load_item_t   pending_loads[$];
  sorted_item_t sorted_expected[$];

  // Shadow copy of the buffer contents for the set being loaded.
  logic signed [31:0] shadow_buf[CAPACITY];
  int    shadow_count;
  logic  shadow_dropped;

  int    fail_count;
  int    loads_sent;
  int    results_seen;
  int    sets_sorted;
  int    idle_cycles;
  int    send_gap;
  int    recv_gap;
  int    hold_off;
  bit    hold_req;
  bit    drain_hold;
  bit    drain_done;

  quicksort_buffer_sorter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one value; on a last item sort the stored set and queue its results.
  task automatic predict_load(input load_item_t it);
    logic signed [31:0] tmp;
    sorted_item_t       r;
    if (shadow_count < CAPACITY) begin
      shadow_buf[shadow_count] = it.value;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (it.last_item) begin
      // Any correct sort gives the same ascending order.
      for (int a = 1; a < shadow_count; a++) begin
        tmp = shadow_buf[a];
        for (int b = a - 1; b >= 0; b--) begin
          if (shadow_buf[b] > tmp) begin
            shadow_buf[b + 1] = shadow_buf[b];
            shadow_buf[b] = tmp;
          end
        end
      end
      for (int k = 0; k < shadow_count; k++) begin
        r.sorted_value = shadow_buf[k];
        r.last_out     = (k == shadow_count - 1);
        r.overflow     = shadow_dropped;
        sorted_expected.push_back(r);
      end
      shadow_count   = 0;
      shadow_dropped = 1'b0;
      sets_sorted++;
    end
  endtask

  function automatic logic [31:0] rand_value(input int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom_range(0, 7) - 3;
      1: v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 2)
                                  : 32'h8000_0000 + $urandom_range(0, 2);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_set(input int n, input int mode);
    load_item_t it;
    for (int k = 0; k < n; k++) begin
      it.value     = rand_value(mode);
      it.last_item = (k == n - 1);
      pending_loads.push_back(it);
    end
  endtask

  task automatic it_send();
    load_item_t it;
    it = pending_loads.pop_front();
    in_tvalid <= 1'b1;
    in_tdata  <= it.value;
    in_tlast  <= it.last_item;
    send_gap  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
  endtask

  initial begin
    load_item_t it;
    int n;
    // Directed: single item, extremes, duplicates, a descending set, then a set that overflows.
    it = '{value: 32'h8000_0000, last_item: 1'b1};
    pending_loads.push_back(it);
    it = '{value: 32'h7fff_ffff, last_item: 1'b0}; pending_loads.push_back(it);
    it = '{value: 32'h0000_0000, last_item: 1'b0}; pending_loads.push_back(it);
    it = '{value: 32'hffff_ffff, last_item: 1'b0}; pending_loads.push_back(it);
    it = '{value: 32'h8000_0000, last_item: 1'b0}; pending_loads.push_back(it);
    it = '{value: 32'h0000_0001, last_item: 1'b1}; pending_loads.push_back(it);
    for (int k = 0; k < 5; k++) begin
      it = '{value: 32'd5, last_item: k == 4};
      pending_loads.push_back(it);
    end
    for (int k = 0; k < 6; k++) begin
      it = '{value: 32'd10 - k, last_item: k == 5};
      pending_loads.push_back(it);
    end
    for (int k = 0; k < CAPACITY + 3; k++) begin
      it = '{value: $urandom, last_item: k == CAPACITY + 2};
      pending_loads.push_back(it);
    end
    // Random sets, mostly small, a few near or past capacity.
    while (pending_loads.size() < 450) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(60, 70);
        1, 2:    n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      queue_set(n, $urandom_range(0, 3));
    end
  end

  // Input driver.
  always @(posedge clk) begin
    bit hold;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tlast   <= 1'b0;
      send_gap   <= 0;
      drain_hold <= 1'b0;
      drain_done <= 1'b0;
    end else begin
      hold = drain_hold;
      if (in_tvalid && in_tready) begin
        predict_load('{value: in_tdata, last_item: in_tlast});
        loads_sent <= loads_sent + 1;
        // once, pause after a set closes until all its results are back
        if (in_tlast && !drain_done && loads_sent >= 300) hold = 1'b1;
      end
      if (hold && sorted_expected.size() == 0) begin
        hold = 1'b0;
        drain_done <= 1'b1;
      end
      drain_hold <= hold;
      if (!in_tvalid || in_tready) begin
        if (hold) begin
          in_tvalid <= 1'b0;
        end else if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_loads.size() > 0) begin
          it_send();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver.
  always @(posedge clk) begin
    sorted_item_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
      hold_off   <= 0;
      hold_req   <= 1'b1;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (sorted_expected.size() == 0) begin
          $display("%0t: unexpected result: actual %h last %b ovf %b", $time,
                   out_tdata, out_tlast, out_tuser);
          fail_count++;
        end else begin
          exp_r = sorted_expected.pop_front();
          if (exp_r !== {out_tdata, out_tlast, out_tuser}) begin
            $display("%0t: mismatch: expected %h last %b ovf %b, actual %h last %b ovf %b",
                     $time, exp_r.sorted_value, exp_r.last_out, exp_r.overflow,
                     out_tdata, out_tlast, out_tuser);
            fail_count++;
          end
        end
      end
      // hold off once for a long stretch while the sender keeps going
      if (hold_req && loads_sent >= 100) begin
        hold_req   <= 1'b0;
        hold_off   <= 400;
        out_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off   <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (out_tready && out_tvalid) begin
        recv_gap   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time,
                 sorted_expected.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    fail_count   = 0;
    loads_sent   = 0;
    results_seen = 0;
    sets_sorted  = 0;
    shadow_count = 0;
    shadow_dropped = 1'b0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pending_loads.size() == 0 && !(in_tvalid === 1'b1));
    wait (sorted_expected.size() == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d values in %0d sorted sets, checked %0d results.",
             loads_sent, sets_sorted, results_seen);
    $display("Sets ranged from one value up to past capacity, with stalls on both sides.");
    if (fail_count == 0 && sorted_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> quicksort_buffer_sorter.f
hw/rtl/qsbs_pkg.sv
hw/rtl/qsbs_ctrl.sv
hw/rtl/qsbs_dp.sv
hw/rtl/quicksort_buffer_sorter.sv
verif/tb_top.sv
